// ===== hdl/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared codes, limits and the result beat type of the P6 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

  localparam int unsigned MAX_DIM   = 16384;
  localparam int unsigned VALUE_CAP = 65536;
  localparam int unsigned VAL_W     = 17;
  localparam int unsigned DIM_W     = 15;
  localparam int unsigned CNT_W     = 14;

  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_HEIGHT = 3'd2;
  localparam logic [2:0] PH_MAXVAL = 3'd3;
  localparam logic [2:0] PH_PIXELS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_FAILED = 3'd6;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_ZERO      = 3'd2;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd3;
  localparam logic [2:0] ERR_MAXVAL    = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  localparam logic [7:0] CH_P       = 8'h50;
  localparam logic [7:0] CH_6       = 8'h36;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] ALPHA      = 8'hff;
  localparam logic [VAL_W-1:0] MAXVAL_OK = VAL_W'(255);

  typedef struct packed {
    logic [1:0]       kind;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [31:0]      bgra;
    logic             last;
    logic [2:0]       cause;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/ppm_p6_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_stream_decoder
// Byte-wide decoder for binary P6 image files: header parse, BGRA pixels.
// ----------------------------------------------------------------------------
// Input channel: one file byte per beat (file_byte, first_byte, last_byte),
// in_valid / in_stall. first_byte restarts the parser before the byte is used.
// Output channel: zero or one result beat per input beat, out_valid /
// out_stall: a header beat once maxval is read, one pixel beat per R,G,B
// triple, or an error beat that tells the consumer to drop the file.
// Registering: a result goes into the output register, or the skid register.
// Throughput: one byte per cycle while in_stall is low; the parser state is
// updated by one pass of combinational logic per byte.
// Stall: a two-entry output buffer (output register plus skid register) keeps
// the input open while one result waits; in_stall rises only once both are
// full and is driven straight from the skid register.
// Reset: synchronous, clears the parser to the magic phase and empties the
// output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_p6_stream_decoder
  import ppm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       file_byte,
  input  wire logic             first_byte,
  input  wire logic             last_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            result_kind,
  output logic [DIM_W-1:0]      image_width,
  output logic [DIM_W-1:0]      image_height,
  output logic [31:0]           pixel_bgra,
  output logic                  last_pixel,
  output logic [2:0]            error_cause
);

  logic [2:0]       parse_phase;
  logic             in_comment;
  logic             token_started;
  logic             digits_ended;
  logic [VAL_W-1:0] token_value;
  logic [1:0]       magic_position;
  logic             magic_bad;
  logic [VAL_W-1:0] width_store;
  logic [VAL_W-1:0] height_store;
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [1:0]       channel_index;
  logic [7:0]       red_hold;
  logic [7:0]       green_hold;

  logic [2:0]       parse_phase_next;
  logic             in_comment_next;
  logic             token_started_next;
  logic             digits_ended_next;
  logic [VAL_W-1:0] token_value_next;
  logic [1:0]       magic_position_next;
  logic             magic_bad_next;
  logic [VAL_W-1:0] width_store_next;
  logic [VAL_W-1:0] height_store_next;
  logic [CNT_W-1:0] column_count_next;
  logic [CNT_W-1:0] row_count_next;
  logic [1:0]       channel_index_next;
  logic [7:0]       red_hold_next;
  logic [7:0]       green_hold_next;

  logic    res_valid;
  result_t res;
  result_t out_beat;
  result_t skid_beat;
  logic    skid_valid;
  logic    accept;
  logic    out_free;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // per-byte parser step
  always_comb begin
    logic             hdr;
    logic             is_space;
    logic             is_digit;
    logic             do_close;
    logic             hdr_ok;
    logic             pix;
    logic             final_pix;
    logic             col_wrap;
    logic [2:0]       err;
    logic [VAL_W+3:0] prod;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;

    hdr       = 1'b0;
    is_space  = 1'b0;
    is_digit  = 1'b0;
    do_close  = 1'b0;
    hdr_ok    = 1'b0;
    pix       = 1'b0;
    final_pix = 1'b0;
    col_wrap  = 1'b0;
    err       = ERR_NONE;
    prod      = '0;
    col_inc   = '0;
    row_inc   = '0;

    parse_phase_next    = parse_phase;
    in_comment_next     = in_comment;
    token_started_next  = token_started;
    digits_ended_next   = digits_ended;
    token_value_next    = token_value;
    magic_position_next = magic_position;
    magic_bad_next      = magic_bad;
    width_store_next    = width_store;
    height_store_next   = height_store;
    column_count_next   = column_count;
    row_count_next      = row_count;
    channel_index_next  = channel_index;
    red_hold_next       = red_hold;
    green_hold_next     = green_hold;

    if (first_byte) begin
      parse_phase_next    = PH_MAGIC;
      in_comment_next     = 1'b0;
      token_started_next  = 1'b0;
      digits_ended_next   = 1'b0;
      token_value_next    = '0;
      magic_position_next = '0;
      magic_bad_next      = 1'b0;
      width_store_next    = '0;
      height_store_next   = '0;
      column_count_next   = '0;
      row_count_next      = '0;
      channel_index_next  = '0;
      red_hold_next       = '0;
      green_hold_next     = '0;
    end

    is_space = (file_byte == CH_SPACE) || (file_byte >= CH_TAB && file_byte <= CH_CR);
    is_digit = (file_byte >= CH_ZERO) && (file_byte <= CH_NINE);
    hdr      = (parse_phase_next <= PH_MAXVAL);

    // pixel bytes
    col_inc  = DIM_W'(column_count_next) + DIM_W'(1);
    row_inc  = DIM_W'(row_count_next) + DIM_W'(1);
    col_wrap = VAL_W'(col_inc) >= width_store_next;
    if (parse_phase_next == PH_PIXELS) begin
      case (channel_index_next)
        2'd0: begin
          red_hold_next      = file_byte;
          channel_index_next = 2'd1;
        end
        2'd1: begin
          green_hold_next    = file_byte;
          channel_index_next = 2'd2;
        end
        default: begin
          channel_index_next = 2'd0;
          pix                = 1'b1;
          final_pix          = col_wrap && (VAL_W'(row_inc) >= height_store_next);
          if (col_wrap) begin
            column_count_next = '0;
            row_count_next    = row_inc[CNT_W-1:0];
          end else begin
            column_count_next = col_inc[CNT_W-1:0];
          end
          if (final_pix) begin
            parse_phase_next = PH_DONE;
          end
        end
      endcase
    end

    // header bytes, token close deferred
    if (hdr) begin
      if (in_comment_next) begin
        if (file_byte == CH_NEWLINE) begin
          in_comment_next = 1'b0;
        end
      end else if (file_byte == CH_HASH) begin
        in_comment_next = 1'b1;
      end else if (is_space) begin
        do_close = token_started_next;
      end else begin
        token_started_next = 1'b1;
        if (parse_phase_next == PH_MAGIC) begin
          if ((magic_position_next == 2'd0 && file_byte != CH_P) ||
              (magic_position_next == 2'd1 && file_byte != CH_6) ||
              (magic_position_next >= 2'd2)) begin
            magic_bad_next = 1'b1;
          end
          if (magic_position_next < 2'd3) begin
            magic_position_next = magic_position_next + 2'd1;
          end
        end else if (!digits_ended_next && is_digit) begin
          prod = ((VAL_W+4)'(token_value_next) << 3) + ((VAL_W+4)'(token_value_next) << 1)
                 + (VAL_W+4)'(file_byte - CH_ZERO);
          if (prod > (VAL_W+4)'(VALUE_CAP)) begin
            token_value_next = VAL_W'(VALUE_CAP);
          end else begin
            token_value_next = prod[VAL_W-1:0];
          end
        end else begin
          digits_ended_next = 1'b1;
        end
      end
      if (last_byte && token_started_next) begin
        do_close = 1'b1;
      end
    end

    if (do_close) begin
      case (parse_phase_next)
        PH_MAGIC: begin
          if (magic_bad_next || magic_position_next != 2'd2) begin
            parse_phase_next = PH_FAILED;
            err              = ERR_MAGIC;
          end else begin
            parse_phase_next = PH_WIDTH;
          end
        end
        PH_WIDTH: begin
          width_store_next = token_value_next;
          parse_phase_next = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          height_store_next = token_value_next;
          parse_phase_next  = PH_MAXVAL;
        end
        default: begin
          if (token_value_next != MAXVAL_OK) begin
            err = ERR_MAXVAL;
          end else if (width_store_next == '0 || height_store_next == '0) begin
            err = ERR_ZERO;
          end else if (width_store_next > VAL_W'(MAX_DIM) ||
                       height_store_next > VAL_W'(MAX_DIM)) begin
            err = ERR_TOO_LARGE;
          end else begin
            hdr_ok = 1'b1;
          end
          if (hdr_ok) begin
            parse_phase_next   = PH_PIXELS;
            column_count_next  = '0;
            row_count_next     = '0;
            channel_index_next = '0;
          end else begin
            parse_phase_next = PH_FAILED;
          end
        end
      endcase
      token_started_next  = 1'b0;
      digits_ended_next   = 1'b0;
      token_value_next    = '0;
      magic_position_next = '0;
      magic_bad_next      = 1'b0;
    end

    // end of file before the image is complete
    if (last_byte && parse_phase_next <= PH_PIXELS) begin
      parse_phase_next = PH_FAILED;
      err              = ERR_TRUNCATED;
      pix              = 1'b0;
      hdr_ok           = 1'b0;
    end

    res       = '0;
    res_valid = 1'b0;
    if (err != ERR_NONE) begin
      res_valid = 1'b1;
      res.kind  = KIND_ERROR;
      res.cause = err;
    end else if (pix) begin
      res_valid  = 1'b1;
      res.kind   = KIND_PIXEL;
      res.width  = width_store_next[DIM_W-1:0];
      res.height = height_store_next[DIM_W-1:0];
      res.bgra   = {ALPHA, red_hold_next, green_hold_next, file_byte};
      res.last   = final_pix;
    end else if (hdr_ok) begin
      res_valid  = 1'b1;
      res.kind   = KIND_HEADER;
      res.width  = width_store_next[DIM_W-1:0];
      res.height = height_store_next[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_MAGIC;
      in_comment     <= 1'b0;
      token_started  <= 1'b0;
      digits_ended   <= 1'b0;
      token_value    <= '0;
      magic_position <= '0;
      magic_bad      <= 1'b0;
      width_store    <= '0;
      height_store   <= '0;
      column_count   <= '0;
      row_count      <= '0;
      channel_index  <= '0;
      red_hold       <= '0;
      green_hold     <= '0;
    end else if (accept) begin
      parse_phase    <= parse_phase_next;
      in_comment     <= in_comment_next;
      token_started  <= token_started_next;
      digits_ended   <= digits_ended_next;
      token_value    <= token_value_next;
      magic_position <= magic_position_next;
      magic_bad      <= magic_bad_next;
      width_store    <= width_store_next;
      height_store   <= height_store_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      channel_index  <= channel_index_next;
      red_hold       <= red_hold_next;
      green_hold     <= green_hold_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_beat   <= skid_beat;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept && res_valid) begin
        out_beat  <= res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (accept && res_valid) begin
      skid_beat  <= res;
      skid_valid <= 1'b1;
    end
  end

  assign result_kind  = out_beat.kind;
  assign image_width  = out_beat.width;
  assign image_height = out_beat.height;
  assign pixel_bgra   = out_beat.bgra;
  assign last_pixel   = out_beat.last;
  assign error_cause  = out_beat.cause;

endmodule

`default_nettype wire
